// ----- hdl/zmf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// zmf_pkg
// Shared constants, types and arithmetic helpers of the zero-mod-N subarray
// finder.
// ----------------------------------------------------------------------------
package zmf_pkg;

    localparam int MAX_LENGTH     = 1024;
    localparam int VALUE_BITS     = 16;
    localparam int INDEX_BITS     = $clog2(MAX_LENGTH);
    localparam int MOD_BITS       = INDEX_BITS + 1;
    localparam int VALUE_CNT_BITS = $clog2(VALUE_BITS);
    localparam int SUM_BITS       = INDEX_BITS + 1;
    localparam int SUM_CNT_BITS   = $clog2(SUM_BITS);
    localparam int EPOCH_BITS     = 8;

    typedef struct packed {
        logic [INDEX_BITS-1:0] residue;
        logic                  final_element;
    } item_t;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] epoch;
        logic [INDEX_BITS-1:0] position;
    } entry_t;

    // Clamps the programmed modulus into the range 1..MAX_LENGTH.
    function automatic logic [MOD_BITS-1:0] effective_modulus(
        input logic [MOD_BITS-1:0] modulus
    );
        logic [MOD_BITS-1:0] m;
        if (modulus == '0) begin
            m = MOD_BITS'(1);
        end else if (modulus > MOD_BITS'(MAX_LENGTH)) begin
            m = MOD_BITS'(MAX_LENGTH);
        end else begin
            m = modulus;
        end
        return m;
    endfunction

    // One step of a restoring remainder: shifts in one dividend bit and
    // subtracts the modulus once when the partial remainder reaches it.
    function automatic logic [INDEX_BITS-1:0] mod_step(
        input logic [INDEX_BITS-1:0] rem,
        input logic                  dividend_bit,
        input logic [MOD_BITS-1:0]   m
    );
        logic [MOD_BITS-1:0] t;
        t = {rem, dividend_bit};
        if (t >= m) begin
            t = t - m;
        end
        return t[INDEX_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- hdl/zmf_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// zmf_if
// Valid/ready channel interfaces for array elements and found ranges.
// ----------------------------------------------------------------------------
interface zmf_in_if;
    logic                            valid;
    logic                            ready;
    logic [zmf_pkg::VALUE_BITS-1:0]  value;
    logic                            final_element;

    modport source (output valid, output value, output final_element, input ready);
    modport sink   (input valid, input value, input final_element, output ready);
endinterface

interface zmf_out_if;
    logic                            valid;
    logic                            ready;
    logic [zmf_pkg::INDEX_BITS-1:0]  first_index;
    logic [zmf_pkg::INDEX_BITS-1:0]  last_index;

    modport source (output valid, output first_index, output last_index, input ready);
    modport sink   (input valid, input first_index, input last_index, output ready);
endinterface
`default_nettype wire

// ----- hdl/zmf_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// zmf_front
// Accepts array elements and reduces each value modulo the modulus, one
// dividend bit per cycle.
// ----------------------------------------------------------------------------
module zmf_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    zmf_in_if.sink                             in_ch,
    input  wire logic [zmf_pkg::MOD_BITS-1:0]  m,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output zmf_pkg::item_t                     push_data
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_RUN,
        F_PUSH
    } state_t;

    state_t                               state_reg, state_next;
    logic [zmf_pkg::VALUE_BITS-1:0]       value_reg, value_next;
    logic [zmf_pkg::INDEX_BITS-1:0]       rem_reg, rem_next;
    logic [zmf_pkg::VALUE_CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                                 last_reg, last_next;

    assign in_ch.ready             = (state_reg == F_IDLE);
    assign push_valid              = (state_reg == F_PUSH);
    assign push_data.residue       = rem_reg;
    assign push_data.final_element = last_reg;

    always_comb
    begin
        state_next = state_reg;
        value_next = value_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_ch.valid)
                begin
                    value_next = in_ch.value;
                    last_next  = in_ch.final_element;
                    rem_next   = '0;
                    cnt_next   = zmf_pkg::VALUE_CNT_BITS'(zmf_pkg::VALUE_BITS - 1);
                    state_next = F_RUN;
                end
            end
            F_RUN:
            begin
                rem_next = zmf_pkg::mod_step(rem_reg, value_reg[cnt_reg], m);
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            value_reg <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            value_reg <= value_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/zmf_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// zmf_queue
// Two-entry queue of reduced elements between the front and the back.
// ----------------------------------------------------------------------------
module zmf_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire zmf_pkg::item_t   push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output zmf_pkg::item_t        pop_data
);

    zmf_pkg::item_t  slot_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/zmf_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// zmf_back
// Updates the running residue, looks it up in the first-position table and
// presents the found range in an output register.
// ----------------------------------------------------------------------------
module zmf_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [zmf_pkg::MOD_BITS-1:0]  m,
    input  wire logic                          pop_valid,
    output logic                               pop_ready,
    input  wire zmf_pkg::item_t                pop_data,
    zmf_out_if.source                          out_ch
);

    localparam int DEPTH = zmf_pkg::MAX_LENGTH;
    localparam logic [zmf_pkg::INDEX_BITS-1:0] LAST_POS =
        zmf_pkg::INDEX_BITS'(zmf_pkg::MAX_LENGTH - 1);
    localparam logic [zmf_pkg::EPOCH_BITS-1:0] FIRST_EPOCH =
        zmf_pkg::EPOCH_BITS'(1);

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_MOD,
        B_READ,
        B_CHECK
    } state_t;

    state_t                              state_reg, state_next;
    logic [zmf_pkg::INDEX_BITS-1:0]      residue_reg, residue_next;
    logic [zmf_pkg::INDEX_BITS-1:0]      pos_reg, pos_next;
    logic                                answer_reg, answer_next;
    logic [zmf_pkg::EPOCH_BITS-1:0]      epoch_reg, epoch_next;
    logic [zmf_pkg::INDEX_BITS-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [zmf_pkg::SUM_BITS-1:0]        sum_reg, sum_next;
    logic [zmf_pkg::SUM_CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [zmf_pkg::INDEX_BITS-1:0]      rem_reg, rem_next;
    logic                                last_reg, last_next;
    logic                                out_valid_reg, out_valid_next;
    logic [zmf_pkg::INDEX_BITS-1:0]      out_first_reg, out_first_next;
    logic [zmf_pkg::INDEX_BITS-1:0]      out_last_reg, out_last_next;

    zmf_pkg::entry_t                     table_mem [DEPTH];
    zmf_pkg::entry_t                     rd_data_reg;
    logic                                mem_we;
    logic [zmf_pkg::INDEX_BITS-1:0]      mem_waddr;
    zmf_pkg::entry_t                     mem_wdata;

    logic                                out_free;
    logic                                hit;
    logic                                finish;
    logic                                finish_last;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.first_index = out_first_reg;
    assign out_ch.last_index  = out_last_reg;
    assign pop_ready          = (state_reg == B_IDLE);
    assign out_free           = !out_valid_reg || out_ch.ready;
    assign hit = (rem_reg == '0) || (rd_data_reg.epoch == epoch_reg);

    always_comb
    begin
        state_next     = state_reg;
        residue_next   = residue_reg;
        pos_next       = pos_reg;
        answer_next    = answer_reg;
        epoch_next     = epoch_reg;
        clr_cnt_next   = clr_cnt_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_first_next = out_first_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_waddr      = rem_reg;
        mem_wdata      = '{epoch: epoch_reg, position: pos_reg};
        finish         = 1'b0;
        finish_last    = last_reg;

        case (state_reg)
            B_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_POS)
                begin
                    epoch_next = FIRST_EPOCH;
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    last_next = pop_data.final_element;
                    if (answer_reg)
                    begin
                        finish      = 1'b1;
                        finish_last = pop_data.final_element;
                    end
                    else
                    begin
                        sum_next   = {1'b0, residue_reg} + {1'b0, pop_data.residue};
                        rem_next   = '0;
                        cnt_next   = zmf_pkg::SUM_CNT_BITS'(zmf_pkg::SUM_BITS - 1);
                        state_next = B_MOD;
                    end
                end
            end
            B_MOD:
            begin
                rem_next = zmf_pkg::mod_step(rem_reg, sum_reg[cnt_reg], m);
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                if (!hit || out_free)
                begin
                    if (hit)
                    begin
                        out_valid_next = 1'b1;
                        out_first_next = (rem_reg == '0) ? '0
                                                         : rd_data_reg.position + 1'b1;
                        out_last_next  = pos_reg;
                        answer_next    = 1'b1;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                    residue_next = rem_reg;
                    if (pos_reg != LAST_POS)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    finish = 1'b1;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next = B_IDLE;
            if (finish_last)
            begin
                residue_next = '0;
                pos_next     = '0;
                answer_next  = 1'b0;
                if (epoch_reg == '1)
                begin
                    clr_cnt_next = '0;
                    state_next   = B_CLEAR;
                end
                else
                begin
                    epoch_next = epoch_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            residue_reg   <= '0;
            pos_reg       <= '0;
            answer_reg    <= 1'b0;
            epoch_reg     <= FIRST_EPOCH;
            clr_cnt_reg   <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_first_reg <= '0;
            out_last_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            residue_reg   <= residue_next;
            pos_reg       <= pos_next;
            answer_reg    <= answer_next;
            epoch_reg     <= epoch_next;
            clr_cnt_reg   <= clr_cnt_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            out_first_reg <= out_first_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= table_mem[rem_reg];
    end

endmodule
`default_nettype wire

// ----- hdl/zero_mod_n_subarray_finder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// zero_mod_n_subarray_finder
// Finds the first contiguous run of an array whose sum is a multiple of the
// programmed modulus and reports it as a first and last index.
// ----------------------------------------------------------------------------
// The front takes one input transaction and reduces the value modulo the
// modulus one bit per cycle, and takes no new element until it has pushed
// the result; the back adds the reduced value to the running residue,
// reduces the sum in 11 serial steps and then reads and updates the
// first-position table, running in parallel with the front through a
// two-entry queue. After reset, and again after every 255 arrays, the back
// clears all 1024 table entries in a pass during which elements wait in
// the queue; the modulus register can be written at any time the block is
// idle.
// ----------------------------------------------------------------------------
module zero_mod_n_subarray_finder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [zmf_pkg::MOD_BITS-1:0]  cfg_wr_data,
    zmf_in_if.sink                             in_ch,
    zmf_out_if.source                          out_ch
);

    logic [zmf_pkg::MOD_BITS-1:0]  modulus_reg;
    logic [zmf_pkg::MOD_BITS-1:0]  m;
    logic                          push_valid;
    logic                          push_ready;
    zmf_pkg::item_t                push_data;
    logic                          pop_valid;
    logic                          pop_ready;
    zmf_pkg::item_t                pop_data;

    assign m = zmf_pkg::effective_modulus(modulus_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= zmf_pkg::MOD_BITS'(1);
        end
        else if (cfg_wr_en)
        begin
            modulus_reg <= cfg_wr_data;
        end
    end

    zmf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .m          (m),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    zmf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    zmf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .m          (m),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .out_ch     (out_ch)
    );

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench for the zero-mod-N subarray finder. Arrays of
// elements are pushed through the input channel under several modulus
// settings, including zero, the largest array length and values above it.
// A local predictor tracks the prefix residue and first sightings of each
// residue and queues each range the accepted elements should produce. Each
// range leaving the block is compared field by field with the oldest queued
// one. Both channels idle at random, and the result side also holds off for
// a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module testbench;

    localparam int     HALF_PERIOD      = 10;
    localparam int     RESET_CYCLES     = 11;
    localparam int     IDLE_PERCENT     = 29;
    localparam int     SETTLE_CYCLES    = 1200;
    localparam int     SINK_HOLD_CYCLES = 700;
    localparam int     RANDOM_ITEMS     = 720;
    localparam int     PHASE_COUNT      = 12;
    localparam longint TIMEOUT_TIME     = 64'd20_000_000;

    typedef struct packed {
        logic [zmf_pkg::INDEX_BITS-1:0] first_index;
        logic [zmf_pkg::INDEX_BITS-1:0] last_index;
    } found_range_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [zmf_pkg::MOD_BITS-1:0]   cfg_wr_data;

    zmf_in_if  in_ch ();
    zmf_out_if out_ch ();

    zero_mod_n_subarray_finder u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    logic [zmf_pkg::MOD_BITS-1:0]   modulus_shadow;
    logic [zmf_pkg::INDEX_BITS-1:0] prefix_residue;
    logic [zmf_pkg::INDEX_BITS-1:0] element_index;
    logic                           range_found;
    bit                             residue_marked [zmf_pkg::MAX_LENGTH];
    logic [zmf_pkg::INDEX_BITS-1:0] residue_origin [zmf_pkg::MAX_LENGTH];
    found_range_t                   expected_ranges [$];

    bit source_idle_on    = 1'b1;
    bit sink_idle_on      = 1'b1;
    bit sink_hold_request = 1'b0;

    int failures       = 0;
    int elements_sent  = 0;
    int arrays_sent    = 0;
    int ranges_checked = 0;

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    initial
    begin : timeout_guard
        #(TIMEOUT_TIME);
        $display("TEST FAILED");
        $finish;
    end

    function automatic void forget_array();
        prefix_residue = '0;
        element_index  = '0;
        range_found    = 1'b0;
        for (int i = 0; i < zmf_pkg::MAX_LENGTH; i++)
        begin
            residue_marked[i] = 1'b0;
        end
    endfunction

    function automatic void track_element(input logic [zmf_pkg::VALUE_BITS-1:0] v,
                                          input logic last);
        int unsigned  m;
        int unsigned  r;
        found_range_t hit;
        if (!range_found)
        begin
            if (modulus_shadow == '0)
            begin
                m = 1;
            end
            else if (modulus_shadow > zmf_pkg::MAX_LENGTH)
            begin
                m = zmf_pkg::MAX_LENGTH;
            end
            else
            begin
                m = 32'(modulus_shadow);
            end
            r = ((32'(prefix_residue) % m) + (32'(v) % m)) % m;
            prefix_residue = r[zmf_pkg::INDEX_BITS-1:0];
            if (r == 0)
            begin
                hit.first_index = '0;
                hit.last_index  = element_index;
                expected_ranges.push_back(hit);
                range_found = 1'b1;
            end
            else if (residue_marked[r])
            begin
                hit.first_index = residue_origin[r] + 1'b1;
                hit.last_index  = element_index;
                expected_ranges.push_back(hit);
                range_found = 1'b1;
            end
            else
            begin
                residue_marked[r] = 1'b1;
                residue_origin[r] = element_index;
            end
            if (element_index < zmf_pkg::MAX_LENGTH - 1)
            begin
                element_index = element_index + 1'b1;
            end
        end
        if (last)
        begin
            forget_array();
        end
    endfunction

    function automatic logic [zmf_pkg::VALUE_BITS-1:0] pick_value(input int span);
        logic [zmf_pkg::VALUE_BITS-1:0] v;
        case ($urandom_range(7, 0))
            0, 1, 2, 3: v = zmf_pkg::VALUE_BITS'($urandom);
            4, 5:       v = zmf_pkg::VALUE_BITS'($urandom_range(span, 0));
            6:          v = zmf_pkg::VALUE_BITS'(span * $urandom_range(64, 0));
            default:    v = $urandom_range(1, 0) ? '1 : '0;
        endcase
        return v;
    endfunction

    task automatic send_element(input logic [zmf_pkg::VALUE_BITS-1:0] v, input logic last);
        if (source_idle_on && $urandom_range(99, 0) < IDLE_PERCENT)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.value         <= v;
        in_ch.final_element <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        track_element(v, last);
        elements_sent++;
        if (last)
        begin
            arrays_sent++;
        end
    endtask

    task automatic send_array(input int len, input int span);
        for (int k = 0; k < len; k++)
        begin
            send_element(pick_value(span), k == len - 1);
        end
    endtask

    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_ranges.size() != 0);
    endtask

    task automatic settle_block();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_modulus(input logic [zmf_pkg::MOD_BITS-1:0] m);
        settle_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        modulus_shadow = m;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_modulus();
        send_element('0, 1'b1);
        send_element('1, 1'b1);
        send_element(16'd1234, 1'b0);
        send_element(16'd77, 1'b1);
    endtask

    task automatic test_directed_ranges();
        write_modulus(zmf_pkg::MOD_BITS'(5));
        send_element(16'd1, 1'b0);
        send_element(16'd2, 1'b0);
        send_element(16'd3, 1'b1);
        send_element(16'd5, 1'b1);
        send_element(16'd2, 1'b0);
        send_element(16'd3, 1'b0);
        send_element(16'd4, 1'b0);
        send_element(16'd4, 1'b1);
        send_element(16'd1, 1'b0);
        send_element(16'd1, 1'b0);
        send_element(16'd1, 1'b0);
        send_element(16'd1, 1'b1);
        send_element(16'd4, 1'b0);
        send_element(16'hFFFF, 1'b1);
        send_element(16'd0, 1'b1);
    endtask

    task automatic test_modulus_change_mid_array();
        write_modulus(zmf_pkg::MOD_BITS'(7));
        send_element(16'd3, 1'b0);
        send_element(16'd5, 1'b0);
        write_modulus(zmf_pkg::MOD_BITS'(4));
        send_element(16'd2, 1'b0);
        send_element(16'd9, 1'b1);
    endtask

    task automatic test_modulus_extremes();
        write_modulus('0);
        send_element(16'hFFFF, 1'b1);
        send_element(16'd0, 1'b0);
        send_element(16'd1, 1'b1);
        write_modulus('1);
        for (int k = 0; k < zmf_pkg::MAX_LENGTH; k++)
        begin
            send_element(16'd1, k == zmf_pkg::MAX_LENGTH - 1);
        end
        write_modulus(zmf_pkg::MOD_BITS'(zmf_pkg::MAX_LENGTH));
        send_element(16'hFFFF, 1'b0);
        send_element(16'hFFFF, 1'b0);
        send_element(16'd1, 1'b1);
    endtask

    task automatic test_output_backpressure();
        write_modulus(zmf_pkg::MOD_BITS'(1));
        sink_hold_request = 1'b1;
        for (int k = 0; k < 40; k++)
        begin
            send_element(zmf_pkg::VALUE_BITS'($urandom), 1'b1);
        end
        settle_block();
    endtask

    task automatic test_random_arrays();
        int moduli [PHASE_COUNT];
        int span;
        int budget;
        int sent_before;
        int cap;
        int len;
        moduli = '{3, 1, 16, 2, 1024, 7, 2047, 64, 0, 300, 5, 32};
        budget = RANDOM_ITEMS / PHASE_COUNT;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_modulus(zmf_pkg::MOD_BITS'(moduli[p]));
            span = (moduli[p] == 0) ? 1 :
                   (moduli[p] > zmf_pkg::MAX_LENGTH ? zmf_pkg::MAX_LENGTH : moduli[p]);
            cap  = (span > 48) ? 48 : span;
            source_idle_on = (p != 4);
            sink_idle_on   = (p != 4);
            sent_before = elements_sent;
            while (elements_sent - sent_before < budget)
            begin
                if ($urandom_range(99, 0) < 85)
                begin
                    len = $urandom_range(cap, 1);
                end
                else
                begin
                    len = $urandom_range(cap + 8, 1);
                end
                send_array(len, span);
                if ($urandom_range(24, 0) == 0)
                begin
                    wait_results_drained();
                end
            end
        end
        source_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
    endtask

    initial
    begin : result_sink
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold_request)
            begin
                sink_hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                for (int k = 0; k < SINK_HOLD_CYCLES; k++)
                begin
                    @(posedge clk);
                end
            end
            else if (sink_idle_on)
            begin
                out_ch.ready <= ($urandom_range(99, 0) >= IDLE_PERCENT);
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : range_monitor
        found_range_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_ranges.size() == 0)
            begin
                $error("unexpected range: first_index %0d last_index %0d",
                       out_ch.first_index, out_ch.last_index);
                failures++;
            end
            else
            begin
                want = expected_ranges.pop_front();
                if (out_ch.first_index !== want.first_index)
                begin
                    $error("first_index expected %0d actual %0d",
                           want.first_index, out_ch.first_index);
                    failures++;
                end
                if (out_ch.last_index !== want.last_index)
                begin
                    $error("last_index expected %0d actual %0d",
                           want.last_index, out_ch.last_index);
                    failures++;
                end
            end
            ranges_checked++;
        end
    end

    initial
    begin : run_tests
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        in_ch.valid         = 1'b0;
        in_ch.value         = '0;
        in_ch.final_element = 1'b0;
        modulus_shadow      = zmf_pkg::MOD_BITS'(1);
        forget_array();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_modulus();
        test_directed_ranges();
        test_modulus_change_mid_array();
        test_modulus_extremes();
        test_output_backpressure();
        test_random_arrays();
        settle_block();
        if (expected_ranges.size() != 0)
        begin
            $error("%0d expected ranges never arrived", expected_ranges.size());
            failures++;
        end
        $display("Run covered %0d elements in %0d arrays and checked %0d ranges,",
                 elements_sent, arrays_sent, ranges_checked);
        $display("with moduli from zero up past the array limit and mid-array changes.");
        if (failures == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
